FILE: sv/gdc_pkg.sv
// Package for the Gregorian day counter: constants, codes and calendar tables.
package gdc_pkg;

  // Request codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Field widths
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 16;
  localparam int ORD_W  = 9;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 16'd65535;

  // Divisibility by 25 over 16 bits: y * inverse(25) mod 2^16 is at most
  // floor((2^16 - 1) / 25) exactly when y is a multiple of 25.
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'(65535 / 25);

  // State after reset: January 1, 2000 (a leap year)
  localparam logic [DAY_W-1:0]  RESET_DAY   = 5'd1;
  localparam logic [MON_W-1:0]  RESET_MONTH = 4'd1;
  localparam logic [YEAR_W-1:0] RESET_YEAR  = 16'd2000;
  localparam logic [YEAR_W-1:0] RESET_M25   = 16'((2000 * 23593) % 65536);
  localparam logic              RESET_LEAP  = 1'b1;

  localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MON_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

  // Leap rule from the year and its scaled residue: multiple of 4, and
  // either not a multiple of 25 or a multiple of 16.
  function automatic logic is_leap(input logic [YEAR_W-1:0] year,
                                   input logic [YEAR_W-1:0] m25);
    logic div25;
    div25   = (m25 <= DIV25_MAX);
    is_leap = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
  endfunction

  // Days in a month; codes outside 1..12 read as January
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] month,
                                                 input logic leap);
    case (month)
      4'd2:    month_len = leap ? 5'd29 : 5'd28;
      4'd4:    month_len = 5'd30;
      4'd6:    month_len = 5'd30;
      4'd9:    month_len = 5'd30;
      4'd11:   month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

  // Days in the months before this one, non-leap year
  function automatic logic [ORD_W-1:0] days_before(input logic [MON_W-1:0] month);
    case (month)
      4'd2:    days_before = 9'd31;
      4'd3:    days_before = 9'd59;
      4'd4:    days_before = 9'd90;
      4'd5:    days_before = 9'd120;
      4'd6:    days_before = 9'd151;
      4'd7:    days_before = 9'd181;
      4'd8:    days_before = 9'd212;
      4'd9:    days_before = 9'd243;
      4'd10:   days_before = 9'd273;
      4'd11:   days_before = 9'd304;
      4'd12:   days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

endpackage

FILE: sv/gregorian_day_counter.sv
// Gregorian calendar day counter: input register, date update, result register.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid / in_stall     | func, set_month, set_day, set_year
//   out     | out_valid / out_stall   | day_out, month_out, year_out,
//           |                         | day_of_year_out, leap_out, month_length_out
//
// One request per cycle while in_stall is low; a taken request loads the input register,
// and its date update is loaded into the result register when the pipeline advances.
// The date registers carry the year scaled by the inverse of 25, so the leap
// flag of the next year comes from one add and compare in the update loop.
// Reset (rst, synchronous) gives January 1, 2000 and empties both stages.
// A stalled result holds both stages; the input stalls only while both are full.
module gregorian_day_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [3:0]  set_month,
  input  logic [4:0]  set_day,
  input  logic [15:0] set_year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  day_out,
  output logic [3:0]  month_out,
  output logic [15:0] year_out,
  output logic [8:0]  day_of_year_out,
  output logic        leap_out,
  output logic [4:0]  month_length_out
);

  // Input register
  logic        s0_valid;
  logic        s0_func;
  logic [3:0]  s0_month;
  logic [4:0]  s0_day;
  logic [15:0] s0_year;
  logic [15:0] s0_m25;
  logic        s0_leap;

  // Date state
  logic [4:0]  day;
  logic [3:0]  month;
  logic [15:0] year;
  logic [15:0] m25;
  logic        leap;

  logic [4:0]  day_next;
  logic [3:0]  month_next;
  logic [15:0] year_next;
  logic [15:0] m25_next;
  logic        leap_next;
  logic [8:0]  ordinal_next;

  logic [15:0] in_m25;
  logic [4:0]  len_cur;
  logic [4:0]  len_load;
  logic [15:0] year_inc;
  logic [15:0] m25_inc;
  logic        advance;
  logic        s0_load;

  // Pipeline moves when the result register is empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s0_valid && !advance;
  assign s0_load  = !s0_valid || advance;

  // Scaled residue of the requested year for the divide-by-25 test
  assign in_m25 = set_year * gdc_pkg::INV25;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_load) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load && in_valid) begin
      s0_func  <= func;
      s0_month <= set_month;
      s0_day   <= set_day;
      s0_year  <= set_year;
      s0_m25   <= in_m25;
      s0_leap  <= gdc_pkg::is_leap(set_year, in_m25);
    end
  end

  // Next date: load with range correction, or advance one day
  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    m25_next   = m25;
    leap_next  = leap;
    len_cur    = gdc_pkg::month_len(month, leap);
    year_inc   = year + 16'd1;
    m25_inc    = m25 + gdc_pkg::INV25;
    len_load   = 5'd31;
    if (s0_func == gdc_pkg::FUNC_LOAD) begin
      if (s0_month inside {[gdc_pkg::MONTH_JAN : gdc_pkg::MONTH_DEC]}) begin
        month_next = s0_month;
      end else begin
        month_next = gdc_pkg::MONTH_JAN;
      end
      len_load  = gdc_pkg::month_len(month_next, s0_leap);
      year_next = s0_year;
      m25_next  = s0_m25;
      leap_next = s0_leap;
      if (s0_day > len_load) begin
        day_next = len_load;
      end else if (s0_day == 5'd0) begin
        day_next = 5'd1;
      end else begin
        day_next = s0_day;
      end
    end else begin
      if (day >= len_cur) begin
        day_next = 5'd1;
        if (month >= gdc_pkg::MONTH_DEC) begin
          month_next = gdc_pkg::MONTH_JAN;
          // year saturates at its maximum
          if (year != gdc_pkg::YEAR_MAX) begin
            year_next = year_inc;
            m25_next  = m25_inc;
            leap_next = gdc_pkg::is_leap(year_inc, m25_inc);
          end
        end else begin
          month_next = month + 4'd1;
        end
      end else begin
        day_next = day + 5'd1;
      end
    end
    // Ordinal day from month offsets, one more from March on in a leap year
    ordinal_next = gdc_pkg::days_before(month_next) + 9'(day_next)
                 + 9'(leap_next && (month_next >= gdc_pkg::MONTH_MAR));
  end

  // Date state
  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= gdc_pkg::RESET_DAY;
      month <= gdc_pkg::RESET_MONTH;
      year  <= gdc_pkg::RESET_YEAR;
      m25   <= gdc_pkg::RESET_M25;
      leap  <= gdc_pkg::RESET_LEAP;
    end else if (advance && s0_valid) begin
      day   <= day_next;
      month <= month_next;
      year  <= year_next;
      m25   <= m25_next;
      leap  <= leap_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s0_valid) begin
      day_out          <= day_next;
      month_out        <= month_next;
      year_out         <= year_next;
      day_of_year_out  <= ordinal_next;
      leap_out         <= leap_next;
      month_length_out <= gdc_pkg::month_len(month_next, leap_next);
    end
  end

endmodule

FILE: tb/gregorian_day_counter_tb.sv
// Testbench for the Gregorian day counter: directed date table, then random requests.
module gregorian_day_counter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int DRAIN_CYCLES  = 8;

  // One reported date, as the block presents it
  typedef struct packed {
    logic [gdc_pkg::DAY_W-1:0]  day;
    logic [gdc_pkg::MON_W-1:0]  month;
    logic [gdc_pkg::YEAR_W-1:0] year;
    logic [gdc_pkg::ORD_W-1:0]  ordinal;
    logic                       leap;
    logic [gdc_pkg::DAY_W-1:0]  mlen;
  } date_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct {
    logic                       f;
    logic [gdc_pkg::MON_W-1:0]  m;
    logic [gdc_pkg::DAY_W-1:0]  d;
    logic [gdc_pkg::YEAR_W-1:0] y;
    bit                         typed;
    date_t                      want;
  } date_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = gdc_pkg::FUNC_TICK;
  logic [3:0]        set_month = '0;
  logic [4:0]        set_day = '0;
  logic [15:0]       set_year = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [4:0]        day_out;
  logic [3:0]        month_out;
  logic [15:0]       year_out;
  logic [8:0]        day_of_year_out;
  logic              leap_out;
  logic [4:0]        month_length_out;

  // Calendar state as the block should hold it
  int unsigned cal_day;
  int unsigned cal_month;
  int unsigned cal_year;

  date_t     pending_dates[$];
  date_row_t date_rows[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  gregorian_day_counter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .set_month(set_month),
    .set_day(set_day),
    .set_year(set_year),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .day_out(day_out),
    .month_out(month_out),
    .year_out(year_out),
    .day_of_year_out(day_of_year_out),
    .leap_out(leap_out),
    .month_length_out(month_length_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      32'(gdc_pkg::MONTH_FEB): return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:             return 30;
      default:                 return 31;
    endcase
  endfunction

  // Ordinal by summing the lengths of the earlier months of this year
  function automatic int unsigned day_of_year(input int unsigned m, input int unsigned d,
                                              input int unsigned y);
    int unsigned total;
    total = d;
    for (int unsigned k = 1; k < m; k++) total += days_in_month(k, y);
    return total;
  endfunction

  // Advance or load the calendar state and report the new date
  task automatic apply_request(input logic f, input logic [gdc_pkg::MON_W-1:0] m,
                               input logic [gdc_pkg::DAY_W-1:0] d,
                               input logic [gdc_pkg::YEAR_W-1:0] y,
                               output date_t res);
    int unsigned nm;
    int unsigned nd;
    int unsigned len;
    if (f == gdc_pkg::FUNC_LOAD) begin
      nm = (m == 4'd0 || m > gdc_pkg::MONTH_DEC) ? 32'(gdc_pkg::MONTH_JAN) : 32'(m);
      len = days_in_month(nm, 32'(y));
      nd = (32'(d) > len) ? len : 32'(d);
      if (nd == 0) nd = 1;
      cal_month = nm;
      cal_day = nd;
      cal_year = 32'(y);
    end else begin
      nd = cal_day + 1;
      if (nd > days_in_month(cal_month, cal_year)) begin
        nd = 1;
        if (cal_month == 32'(gdc_pkg::MONTH_DEC)) begin
          cal_month = 32'(gdc_pkg::MONTH_JAN);
          if (cal_year != 32'(gdc_pkg::YEAR_MAX)) cal_year++;
        end else begin
          cal_month++;
        end
      end
      cal_day = nd;
    end
    res.day     = 5'(cal_day);
    res.month   = 4'(cal_month);
    res.year    = 16'(cal_year);
    res.ordinal = 9'(day_of_year(cal_month, cal_day, cal_year));
    res.leap    = leap_year(cal_year);
    res.mlen    = 5'(days_in_month(cal_month, cal_year));
  endtask

  // Present one request from a falling edge, hold it until taken, return at a falling edge
  task automatic send_request(input logic f, input logic [gdc_pkg::MON_W-1:0] m,
                              input logic [gdc_pkg::DAY_W-1:0] d,
                              input logic [gdc_pkg::YEAR_W-1:0] y,
                              input bit typed, input date_t want);
    date_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    set_month <= m;
    set_day   <= d;
    set_year  <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(f, m, d, y, pred);
    pending_dates.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic add_row(input logic f, input int unsigned m, input int unsigned d,
                         input int unsigned y, input int unsigned typed, input int unsigned wd,
                         input int unsigned wm, input int unsigned wy, input int unsigned wo,
                         input int unsigned wl, input int unsigned wlen);
    date_row_t r;
    r.f = f;
    r.m = 4'(m);
    r.d = 5'(d);
    r.y = 16'(y);
    r.typed = (typed != 0);
    r.want = '{day: 5'(wd), month: 4'(wm), year: 16'(wy), ordinal: 9'(wo),
               leap: (wl != 0), mlen: 5'(wlen)};
    date_rows.push_back(r);
  endtask

  // Random request: mostly day ticks, loads biased toward month ends, century years and years near the maximum
  task automatic send_random;
    logic                       f;
    logic [gdc_pkg::MON_W-1:0]  m;
    logic [gdc_pkg::DAY_W-1:0]  d;
    logic [gdc_pkg::YEAR_W-1:0] y;
    f = ($urandom_range(99) < 25) ? gdc_pkg::FUNC_LOAD : gdc_pkg::FUNC_TICK;
    m = ($urandom_range(99) < 85) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(15));
    d = $urandom_range(1) ? 5'($urandom_range(31, 27)) : 5'($urandom_range(31));
    case ($urandom_range(3))
      0:       y = 16'($urandom_range(65535));
      1:       y = 16'(100 * $urandom_range(655));
      2:       y = 16'($urandom_range(65535, 65528));
      default: y = 16'($urandom_range(2101, 1899));
    endcase
    send_request(f, m, d, y, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Compare each taken result with the oldest pending date
  always @(posedge clk) begin
    date_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, got %0d/%0d/%0d", $realtime,
                 month_out, day_out, year_out);
      end else begin
        want = pending_dates.pop_front();
        check_field("day_out", 32'(want.day), 32'(day_out));
        check_field("month_out", 32'(want.month), 32'(month_out));
        check_field("year_out", 32'(want.year), 32'(year_out));
        check_field("day_of_year_out", 32'(want.ordinal), 32'(day_of_year_out));
        check_field("leap_out", 32'(want.leap), 32'(leap_out));
        check_field("month_length_out", 32'(want.mlen), 32'(month_length_out));
      end
    end
  end

  // Hard stop on a hung handshake
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[gregorian_day_counter] ERROR");
    $finish;
  end

  initial begin
    cal_day   = 32'(gdc_pkg::RESET_DAY);
    cal_month = 32'(gdc_pkg::RESET_MONTH);
    cal_year  = 32'(gdc_pkg::RESET_YEAR);

    // Directed dates: reset value, extremes, clamps, leap rule, year saturation
    add_row(gdc_pkg::FUNC_TICK, 0, 0, 0, 1, 2, 1, 2000, 2, 1, 31);
    add_row(gdc_pkg::FUNC_LOAD, 12, 31, 65535, 1, 31, 12, 65535, 365, 0, 31);
    add_row(gdc_pkg::FUNC_TICK, 0, 0, 0, 1, 1, 1, 65535, 1, 0, 31);
    add_row(gdc_pkg::FUNC_LOAD, 0, 0, 0, 1, 1, 1, 0, 1, 1, 31);
    add_row(gdc_pkg::FUNC_LOAD, 15, 31, 1900, 1, 31, 1, 1900, 31, 0, 31);
    add_row(gdc_pkg::FUNC_LOAD, 2, 31, 1900, 1, 28, 2, 1900, 59, 0, 28);
    add_row(gdc_pkg::FUNC_TICK, 0, 0, 0, 1, 1, 3, 1900, 60, 0, 31);
    add_row(gdc_pkg::FUNC_LOAD, 2, 31, 2000, 1, 29, 2, 2000, 60, 1, 29);
    add_row(gdc_pkg::FUNC_TICK, 0, 0, 0, 1, 1, 3, 2000, 61, 1, 31);
    add_row(gdc_pkg::FUNC_LOAD, 2, 29, 2024, 1, 29, 2, 2024, 60, 1, 29);
    add_row(gdc_pkg::FUNC_LOAD, 2, 30, 2023, 1, 28, 2, 2023, 59, 0, 28);
    add_row(gdc_pkg::FUNC_LOAD, 12, 31, 2024, 1, 31, 12, 2024, 366, 1, 31);
    add_row(gdc_pkg::FUNC_TICK, 0, 0, 0, 1, 1, 1, 2025, 1, 0, 31);
    add_row(gdc_pkg::FUNC_LOAD, 4, 31, 2021, 1, 30, 4, 2021, 120, 0, 30);
    add_row(gdc_pkg::FUNC_TICK, 0, 0, 0, 1, 1, 5, 2021, 121, 0, 31);
    add_row(gdc_pkg::FUNC_LOAD, 13, 5, 2100, 1, 5, 1, 2100, 5, 0, 31);
    add_row(gdc_pkg::FUNC_LOAD, 2, 29, 2100, 1, 28, 2, 2100, 59, 0, 28);
    add_row(gdc_pkg::FUNC_LOAD, 2, 29, 2400, 1, 29, 2, 2400, 60, 1, 29);
    add_row(gdc_pkg::FUNC_LOAD, 10, 21, 16'hAAAA, 1, 21, 10, 16'hAAAA, 294, 0, 31);
    add_row(gdc_pkg::FUNC_LOAD, 5, 10, 16'h5555, 1, 10, 5, 16'h5555, 130, 0, 31);
    add_row(gdc_pkg::FUNC_LOAD, 11, 30, 65535, 0, 0, 0, 0, 0, 0, 0);
    add_row(gdc_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(gdc_pkg::FUNC_LOAD, 6, 31, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(gdc_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    stall_pct = 54;
    foreach (date_rows[i]) begin
      send_request(date_rows[i].f, date_rows[i].m, date_rows[i].d, date_rows[i].y,
                   date_rows[i].typed, date_rows[i].want);
    end

    // Random phases: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 30; stall_pct = 54; end
        1:       begin send_idle_pct = 54; stall_pct = 30; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      repeat (RANDOM_PER_PHASE) send_random();
    end
    in_valid <= 1'b0;

    // Drain outstanding results
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[gregorian_day_counter] OK");
    end else begin
      $display("[gregorian_day_counter] ERROR");
    end
    $finish;
  end

endmodule
